// ----- rtl/dfsa_pkg.sv -----
`timescale 1ns / 1ps
package dfsa_pkg;
  localparam int NumSlots = 256;
  localparam int ParkDepth = 16;
  localparam int NumQueues = 3;
  localparam int TokenWidth = 32;
  localparam int SlotW = $clog2(NumSlots);
  localparam int ParkW = (ParkDepth > 1) ? $clog2(ParkDepth) : 1;
  localparam int WordW = 32;
  localparam int NumWords = NumSlots / WordW;
  localparam int WordIdxW = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int BitIdxW = $clog2(WordW);

  localparam logic [1:0] StatusDone = 2'd0;
  localparam logic [1:0] StatusDeferred = 2'd1;
  localparam logic [1:0] StatusNoSlots = 2'd2;
  localparam logic [1:0] StatusParkFull = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [7:0]  slot;
    logic [31:0] submitted_q0;
    logic [31:0] submitted_q1;
    logic [31:0] submitted_q2;
    logic [31:0] completed_q0;
    logic [31:0] completed_q1;
    logic [31:0] completed_q2;
  } in_item_t;

  typedef struct packed {
    logic [7:0] slot_out;
    logic [1:0] status;
  } out_item_t;

  typedef logic [NumQueues*TokenWidth-1:0] tokens_t;

  function automatic logic tokens_done(input tokens_t tok, input tokens_t done);
    logic ok;
    ok = 1'b1;
    for (int q = 0; q < NumQueues; q++) begin
      if (tok[q*TokenWidth +: TokenWidth] != '0 &&
          tok[q*TokenWidth +: TokenWidth] > done[q*TokenWidth +: TokenWidth]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction
endpackage

// ----- rtl/deferred_free_slot_allocator.sv -----
`timescale 1ns / 1ps
// Retire: if the tokens are done (or tracking is off), the free map word is read, set and
// written back; else the slot is parked or park full is reported. StFinish sets out_valid_o.
// Allocate: each park entry passes StPRead and StPCheck, and each entry freed also StPSet;
// then StScan examines the 32-bit free map words in turn; StFinish sets out_valid_o.
// One item is in work at a time; the next item is taken once the result register is empty.
// Reset clears the control state and the park valid bits; the free map is cleared by a pass of
// one word per cycle over its eight words after reset, during which no item is accepted.
module deferred_free_slot_allocator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dfsa_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dfsa_pkg::out_item_t  out_item_o
);
  import dfsa_pkg::*;

  typedef enum logic [7:0] {
    StClear  = 8'b0000_0001,
    StIdle   = 8'b0000_0010,
    StPRead  = 8'b0000_0100,
    StPCheck = 8'b0000_1000,
    StPSet   = 8'b0001_0000,
    StScan   = 8'b0010_0000,
    StRetire = 8'b0100_0000,
    StFinish = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic track_q;

  logic [WordW-1:0] fmem [NumWords];
  logic [WordW-1:0] frd_q;
  logic             fre, fwe;
  logic [WordIdxW-1:0] fra, fwa;
  logic [WordW-1:0] fwd;

  logic [SlotW-1:0] pslot_mem [ParkDepth];
  tokens_t          ptok_mem  [ParkDepth];
  logic [SlotW-1:0] pslot_q;
  tokens_t          ptok_q;
  logic             pwe;
  logic [ParkW-1:0] pwa, pra;
  logic [ParkDepth-1:0] pvalid_q, pvalid_d;

  in_item_t  item_q;
  tokens_t   sub_w, done_w;
  logic [ParkW:0] pidx_q, pidx_d;
  logic [WordIdxW:0] widx_q, widx_d;
  logic [SlotW:0] fresh_q, fresh_d;
  logic [SlotW-1:0] res_slot_q, res_slot_d;
  logic [1:0] res_st_q, res_st_d;
  logic oval_q, oval_d;
  logic accept;
  logic [BitIdxW-1:0] lowbit;
  logic anybit;
  logic [ParkW-1:0] freeidx;
  logic anyfree;

  assign sub_w  = {item_q.submitted_q2, item_q.submitted_q1, item_q.submitted_q0};
  assign done_w = {item_q.completed_q2, item_q.completed_q1, item_q.completed_q0};

  assign in_stall_o  = !(state_q == StIdle) || oval_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = oval_q;
  assign out_item_o.slot_out = 8'(res_slot_q);
  assign out_item_o.status   = res_st_q;

  always_comb begin
    lowbit = '0;
    anybit = 1'b0;
    for (int b = WordW - 1; b >= 0; b--) begin
      if (frd_q[b]) begin
        lowbit = BitIdxW'(b);
        anybit = 1'b1;
      end
    end
    freeidx = '0;
    anyfree = 1'b0;
    for (int p = ParkDepth - 1; p >= 0; p--) begin
      if (!pvalid_q[p]) begin
        freeidx = ParkW'(p);
        anyfree = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    pvalid_d = pvalid_q;
    pidx_d = pidx_q;
    widx_d = widx_q;
    fresh_d = fresh_q;
    res_slot_d = res_slot_q;
    res_st_d = res_st_q;
    oval_d = oval_q && out_stall_i;
    fre = 1'b0;
    fra = '0;
    fwe = 1'b0;
    fwa = '0;
    fwd = frd_q;
    pwe = 1'b0;
    pwa = freeidx;
    pra = pidx_q[ParkW-1:0];
    unique case (state_q)
      StClear: begin
        fwe = 1'b1;
        fwa = widx_q[WordIdxW-1:0];
        fwd = '0;
        widx_d = widx_q + 1'b1;
        if (widx_q == (WordIdxW+1)'(NumWords - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          pidx_d = '0;
          widx_d = '0;
          res_slot_d = '0;
          res_st_d = StatusDone;
          state_d = in_item_i.mode ? StRetire : StPRead;
          fre = in_item_i.mode;
          fra = WordIdxW'(in_item_i.slot[SlotW-1:0] >> BitIdxW);
        end
      end
      StRetire: begin
        if (!track_q || tokens_done(sub_w, done_w)) begin
          fwe = 1'b1;
          fwa = WordIdxW'(item_q.slot[SlotW-1:0] >> BitIdxW);
          fwd = frd_q | (WordW'(1) << item_q.slot[BitIdxW-1:0]);
        end else if (anyfree) begin
          pwe = 1'b1;
          pvalid_d[freeidx] = 1'b1;
          res_st_d = StatusDeferred;
        end else begin
          res_st_d = StatusParkFull;
        end
        state_d = StFinish;
      end
      StPRead: begin
        state_d = StPCheck;
      end
      StPCheck: begin
        if (pvalid_q[pidx_q[ParkW-1:0]] && (!track_q || tokens_done(ptok_q, done_w))) begin
          pvalid_d[pidx_q[ParkW-1:0]] = 1'b0;
          fre = 1'b1;
          fra = WordIdxW'(pslot_q >> BitIdxW);
          state_d = StPSet;
        end else begin
          pidx_d = pidx_q + 1'b1;
          if (pidx_q == (ParkW+1)'(ParkDepth - 1)) begin
            state_d = StScan;
            fre = 1'b1;
            fra = '0;
          end else begin
            state_d = StPRead;
          end
        end
      end
      StPSet: begin
        fwe = 1'b1;
        fwa = WordIdxW'(pslot_q >> BitIdxW);
        fwd = frd_q | (WordW'(1) << pslot_q[BitIdxW-1:0]);
        pidx_d = pidx_q + 1'b1;
        if (pidx_q == (ParkW+1)'(ParkDepth - 1)) begin
          state_d = StScan;
          fre = 1'b1;
          fra = '0;
        end else begin
          state_d = StPRead;
        end
      end
      StScan: begin
        if (anybit) begin
          fwe = 1'b1;
          fwa = widx_q[WordIdxW-1:0];
          fwd = frd_q & ~(WordW'(1) << lowbit);
          res_slot_d = SlotW'({widx_q[WordIdxW-1:0], lowbit});
          state_d = StFinish;
        end else if (widx_q == (WordIdxW+1)'(NumWords - 1)) begin
          if (fresh_q < (SlotW+1)'(NumSlots)) begin
            res_slot_d = fresh_q[SlotW-1:0];
            fresh_d = fresh_q + 1'b1;
          end else begin
            res_st_d = StatusNoSlots;
          end
          state_d = StFinish;
        end else begin
          widx_d = widx_q + 1'b1;
          fre = 1'b1;
          fra = widx_q[WordIdxW-1:0] + 1'b1;
        end
      end
      StFinish: begin
        oval_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fwe) begin
      fmem[fwa] <= fwd;
    end
    if (fre) begin
      if (fwe && (fwa == fra)) begin
        frd_q <= fwd;
      end else begin
        frd_q <= fmem[fra];
      end
    end
    if (pwe) begin
      pslot_mem[pwa] <= item_q.slot[SlotW-1:0];
      ptok_mem[pwa]  <= sub_w;
    end
    pslot_q <= pslot_mem[pra];
    ptok_q  <= ptok_mem[pra];
    if (accept) begin
      item_q <= in_item_i;
    end
    res_slot_q <= res_slot_d;
    res_st_q <= res_st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      track_q <= 1'b1;
      pvalid_q <= '0;
      pidx_q <= '0;
      widx_q <= '0;
      fresh_q <= '0;
      oval_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        track_q <= cfg_wdata_i;
      end
      pvalid_q <= pvalid_d;
      pidx_q <= pidx_d;
      widx_q <= widx_d;
      fresh_q <= fresh_d;
      oval_q <= oval_d;
    end
  end
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import dfsa_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeRetire = 1'b1;

  always #6 clk_i = ~clk_i;

  deferred_free_slot_allocator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  class slot_scoreboard;
    bit tracking;
    bit free_map[NumSlots];
    int unsigned next_fresh;
    bit park_valid[ParkDepth];
    logic [7:0] park_slot[ParkDepth];
    logic [31:0] park_tok[ParkDepth][NumQueues];
    out_item_t pending_q[$];
    int errors;
    int n_alloc, n_retire, n_deferred, n_noslots, n_full;

    function new();
      tracking = 1'b1;
      next_fresh = 0;
      errors = 0;
      foreach (free_map[i]) free_map[i] = 1'b0;
      foreach (park_valid[i]) park_valid[i] = 1'b0;
    endfunction

    function bit complete(logic [31:0] tok[NumQueues], logic [31:0] done[NumQueues]);
      if (!tracking) return 1'b1;
      for (int q = 0; q < NumQueues; q++)
        if (tok[q] != 0 && tok[q] > done[q]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_input(in_item_t it);
      logic [31:0] sub[NumQueues];
      logic [31:0] done[NumQueues];
      out_item_t r;
      bit found;
      sub[0] = it.submitted_q0; sub[1] = it.submitted_q1; sub[2] = it.submitted_q2;
      done[0] = it.completed_q0; done[1] = it.completed_q1; done[2] = it.completed_q2;
      r = '0;
      found = 1'b0;
      if (it.mode == ModeAlloc) begin
        n_alloc++;
        for (int p = 0; p < ParkDepth; p++) begin
          if (park_valid[p] && complete(park_tok[p], done)) begin
            free_map[park_slot[p]] = 1'b1;
            park_valid[p] = 1'b0;
          end
        end
        for (int s = 0; s < NumSlots; s++) begin
          if (!found && free_map[s]) begin
            free_map[s] = 1'b0;
            r.slot_out = 8'(s);
            found = 1'b1;
          end
        end
        if (!found) begin
          if (next_fresh < NumSlots) begin
            r.slot_out = 8'(next_fresh);
            next_fresh++;
          end else begin
            r.status = StatusNoSlots;
            n_noslots++;
          end
        end
      end else begin
        n_retire++;
        if (complete(sub, done)) begin
          free_map[it.slot] = 1'b1;
        end else begin
          r.status = StatusParkFull;
          for (int p = 0; p < ParkDepth; p++) begin
            if (!found && !park_valid[p]) begin
              park_valid[p] = 1'b1;
              park_slot[p] = it.slot;
              park_tok[p] = sub;
              r.status = StatusDeferred;
              found = 1'b1;
            end
          end
          if (found) n_deferred++;
          else n_full++;
        end
      end
      pending_q = {pending_q, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result slot_out=%0d status=%0d", $time,
                 got.slot_out, got.status);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.slot_out !== want.slot_out) begin
        $display("%0t: slot_out expected %0d actual %0d", $time, want.slot_out, got.slot_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  slot_scoreboard sb;
  int unsigned cycle_count = 0;
  bit in_gaps = 1'b1;
  bit out_gaps = 1'b1;

  // Fence state used to build plausible token streams.
  logic [31:0] last_sub[NumQueues];
  logic [31:0] last_done[NumQueues];

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  initial begin : stall_gen
    int n;
    wait (rst_ni);
    forever begin
      n = out_gaps ? $urandom_range(0, 13) : 0;
      if ($urandom_range(0, 5) == 0) n = 0;
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send(in_item_t it);
    int gap;
    gap = in_gaps ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_tracking(bit v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.tracking = v;
  endtask

  function automatic in_item_t make_item(logic mode, logic [7:0] slot,
                                         logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
                                         logic [31:0] c0, logic [31:0] c1, logic [31:0] c2);
    in_item_t it;
    it.mode = mode; it.slot = slot;
    it.submitted_q0 = s0; it.submitted_q1 = s1; it.submitted_q2 = s2;
    it.completed_q0 = c0; it.completed_q1 = c1; it.completed_q2 = c2;
    return it;
  endfunction

  function automatic logic [31:0] rand32();
    return $urandom();
  endfunction

  // Mostly a monotone fence stream; sometimes wholly random tokens.
  function automatic in_item_t random_item(int alloc_pct);
    logic [31:0] s[NumQueues];
    logic [31:0] c[NumQueues];
    logic mode;
    mode = ($urandom_range(0, 99) < alloc_pct) ? ModeAlloc : ModeRetire;
    for (int q = 0; q < NumQueues; q++) begin
      if ($urandom_range(0, 9) == 0) begin
        s[q] = rand32();
        c[q] = rand32();
      end else begin
        last_sub[q] = last_sub[q] + $urandom_range(0, 3);
        if (last_done[q] < last_sub[q] && $urandom_range(0, 2) == 0)
          last_done[q] = last_done[q] + $urandom_range(1, 2);
        s[q] = ($urandom_range(0, 3) == 0) ? 32'd0 : last_sub[q];
        c[q] = last_done[q];
      end
    end
    return make_item(mode, 8'($urandom_range(0, 255)), s[0], s[1], s[2], c[0], c[1], c[2]);
  endfunction

  initial begin
    sb = new();
    for (int q = 0; q < NumQueues; q++) begin
      last_sub[q] = 32'h8000_0000 + $urandom_range(0, 1000);
      last_done[q] = last_sub[q];
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fresh allocation, retire and reuse, deferral, park full, extremes.
    send(make_item(ModeAlloc, 8'hff, '1, '1, '1, '0, '0, '0));
    send(make_item(ModeAlloc, 8'h00, '0, '0, '0, '0, '0, '0));
    send(make_item(ModeRetire, 8'd0, '0, '0, '0, '0, '0, '0));
    send(make_item(ModeRetire, 8'd0, '0, '0, '0, '0, '0, '0));
    send(make_item(ModeAlloc, 8'd0, '0, '0, '0, '0, '0, '0));
    for (int i = 0; i < 17; i++)
      send(make_item(ModeRetire, 8'(i * 15), 32'd5, '1, 32'd0, 32'd4, '1, '1));
    send(make_item(ModeAlloc, 8'd0, '0, '0, '0, 32'd4, '1, '1));
    send(make_item(ModeAlloc, 8'd0, '0, '0, '0, '1, '0, '0));
    send(make_item(ModeRetire, 8'hff, '1, '1, '1, '1, '1, '1));

    // Pause until everything has drained, then run without idling for a while.
    drain();
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    for (int i = 0; i < 100; i++) send(random_item(50));
    in_gaps = 1'b1;
    out_gaps = 1'b1;

    write_tracking(1'b0);
    for (int i = 0; i < 200; i++) send(random_item(50));
    write_tracking(1'b1);
    // Allocation-heavy stretch to exhaust the slot space.
    for (int i = 0; i < 450; i++) send(random_item(80));
    for (int i = 0; i < 400; i++) send(random_item(45));
    write_tracking(1'b0);
    for (int i = 0; i < 100; i++) send(random_item(50));
    write_tracking(1'b1);
    for (int i = 0; i < 150; i++) send(random_item(40));

    drain();
    $display("Covered %0d allocations and %0d retirements with both tracking settings.",
             sb.n_alloc, sb.n_retire);
    $display("Deferred %0d, park list full %0d, out of slots %0d.",
             sb.n_deferred, sb.n_full, sb.n_noslots);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- deferred_free_slot_allocator.f -----
rtl/dfsa_pkg.sv
rtl/deferred_free_slot_allocator.sv
tb/sv/tb.sv
